// ----- rtl/pstq_pkg.sv -----
// ----------------------------------------------------------------------------
// pstq_pkg
// shared constants and codes for the prefix-sum range query table
// ----------------------------------------------------------------------------
package pstq_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = 10;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CountW     = 11;
  localparam int unsigned ModeW      = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

endpackage

// ----- rtl/pstq_ram.sv -----
// ----------------------------------------------------------------------------
// pstq_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module pstq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/prefix_sum_range_query_table_core.sv -----
// ----------------------------------------------------------------------------
// prefix_sum_range_query_table_core
// element table plus running prefix-sum table with range query and update
// ----------------------------------------------------------------------------
// sequence: a load writes both tables when accepted; a valid query reads prefix[end]
//   and, for a start above 0, prefix[start-1]; an update reads the old element
//   and walks the prefix table from index to count-1 when index is below count
// throughput: one item at a time; the next item is accepted only in S_IDLE
// reset: synchronous, active high; clears control, running sum, count to 1024;
//   the rams are not cleared and hold nothing valid until loaded
module prefix_sum_range_query_table_core (
  input  logic                                clk,
  input  logic                                rst,
  // item input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pstq_pkg::ModeW-1:0]          mode,
  input  logic [pstq_pkg::AddrW-1:0]          index,
  input  logic [pstq_pkg::AddrW-1:0]          range_end,
  input  logic signed [pstq_pkg::DataW-1:0]   value,
  // result output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pstq_pkg::DataW-1:0]   range_sum,
  output logic                                status,
  // element_count write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pstq_pkg::CountW-1:0]         cfg_data
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,    // waiting for an item
    S_QLAST,   // query from 0: prefix[end] arriving
    S_QFIRST,  // query: prefix[end] arriving, prefix[start-1] being read
    S_QSUB,    // query: prefix[start-1] arriving
    S_UELEM,   // update: old element arriving
    S_WALK,    // update: read-modify-write across the prefix table
    S_DONE     // result ready, waiting for the output register
  } state_t;

  state_t state;

  // configuration and running state
  logic [pstq_pkg::CountW-1:0] element_count;
  logic [pstq_pkg::CountW-1:0] count;
  logic [pstq_pkg::DataW-1:0]  running_sum;
  logic [pstq_pkg::DataW-1:0]  running_sum_next;

  // latched item
  logic [pstq_pkg::AddrW-1:0]  pos;
  logic [pstq_pkg::DataW-1:0]  new_val;
  logic [pstq_pkg::DataW-1:0]  diff;
  logic [pstq_pkg::DataW-1:0]  acc;
  logic [pstq_pkg::AddrW-1:0]  walk_idx;
  logic [pstq_pkg::CountW-1:0] walk_next;

  // pending result
  logic [pstq_pkg::DataW-1:0]  res_sum;
  logic                        res_status;

  // ram ports
  logic                        elem_we;
  logic [pstq_pkg::AddrW-1:0]  elem_wr_addr;
  logic [pstq_pkg::DataW-1:0]  elem_wr_data;
  logic [pstq_pkg::AddrW-1:0]  elem_rd_addr;
  logic [pstq_pkg::DataW-1:0]  elem_rd_data;
  logic                        pfx_we;
  logic [pstq_pkg::AddrW-1:0]  pfx_wr_addr;
  logic [pstq_pkg::DataW-1:0]  pfx_wr_data;
  logic [pstq_pkg::AddrW-1:0]  pfx_rd_addr;
  logic [pstq_pkg::DataW-1:0]  pfx_rd_data;

  // handshake terms
  logic in_xfer;
  logic out_free;
  logic query_bad;
  logic upd_in_range;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // output register is empty or its transfer completes this cycle
  assign out_free  = !out_valid || !out_stall;

  // effective count, limited to the table depth
  assign count = (element_count > pstq_pkg::CountW'(pstq_pkg::TableDepth))
               ? pstq_pkg::CountW'(pstq_pkg::TableDepth) : element_count;

  // start after end, or end at or past the count
  assign query_bad = (index > range_end) ||
                     ({1'b0, range_end} >= count);

  assign upd_in_range = ({1'b0, pos} < count);
  assign walk_next    = {1'b0, walk_idx} + pstq_pkg::CountW'(1);

  // a load at index 0 restarts the running sum
  assign running_sum_next = (index == '0) ? value : running_sum + value;

  // ram addressing and write strobes
  always_comb begin
    elem_we      = 1'b0;
    elem_wr_addr = pos;
    elem_wr_data = new_val;
    elem_rd_addr = index;
    pfx_we       = 1'b0;
    pfx_wr_addr  = walk_idx;
    pfx_wr_data  = pfx_rd_data + diff;
    pfx_rd_addr  = range_end;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && mode == pstq_pkg::MODE_LOAD) begin
          // load writes element and prefix in the accept cycle
          elem_we      = 1'b1;
          elem_wr_addr = index;
          elem_wr_data = value;
          pfx_we       = 1'b1;
          pfx_wr_addr  = index;
          pfx_wr_data  = running_sum_next;
        end
      end
      S_QFIRST: begin
        pfx_rd_addr = pos - pstq_pkg::AddrW'(1);
      end
      S_UELEM: begin
        elem_we     = 1'b1;
        pfx_rd_addr = pos;
      end
      S_WALK: begin
        // write entry i while reading entry i+1, never the same entry
        pfx_we      = 1'b1;
        pfx_rd_addr = walk_next[pstq_pkg::AddrW-1:0];
      end
      S_QLAST, S_QSUB, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  pstq_ram #(
    .Width (pstq_pkg::DataW),
    .Depth (pstq_pkg::TableDepth)
  ) u_elem_ram (
    .clk     (clk),
    .we      (elem_we),
    .wr_addr (elem_wr_addr),
    .wr_data (elem_wr_data),
    .rd_addr (elem_rd_addr),
    .rd_data (elem_rd_data)
  );

  pstq_ram #(
    .Width (pstq_pkg::DataW),
    .Depth (pstq_pkg::TableDepth)
  ) u_pfx_ram (
    .clk     (clk),
    .we      (pfx_we),
    .wr_addr (pfx_wr_addr),
    .wr_data (pfx_wr_data),
    .rd_addr (pfx_rd_addr),
    .rd_data (pfx_rd_data)
  );

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      running_sum   <= '0;
      element_count <= pstq_pkg::CountW'(pstq_pkg::TableDepth);
    end else begin
      if (cfg_valid && cfg_ready) begin
        element_count <= cfg_data;
      end
      // output transfer drains the register unless a new result refills it
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pos        <= index;
            new_val    <= value;
            res_sum    <= '0;
            // only an invalid query is flagged
            res_status <= (mode == pstq_pkg::MODE_QUERY && query_bad)
                        ? pstq_pkg::StatusBad : pstq_pkg::StatusOk;
            priority case (mode)
              pstq_pkg::MODE_LOAD: begin
                running_sum <= running_sum_next;
                state       <= S_DONE;
              end
              pstq_pkg::MODE_QUERY: begin
                if (query_bad) begin
                  state <= S_DONE;
                end else if (index == '0) begin
                  state <= S_QLAST;
                end else begin
                  state <= S_QFIRST;
                end
              end
              pstq_pkg::MODE_UPDATE: begin
                state <= S_UELEM;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_QLAST: begin
          res_sum <= pfx_rd_data;
          state   <= S_DONE;
        end
        S_QFIRST: begin
          acc   <= pfx_rd_data;
          state <= S_QSUB;
        end
        S_QSUB: begin
          res_sum <= acc - pfx_rd_data;
          state   <= S_DONE;
        end
        S_UELEM: begin
          diff     <= new_val - elem_rd_data;
          walk_idx <= pos;
          // update at or past the count only stores the element
          state    <= upd_in_range ? S_WALK : S_DONE;
        end
        S_WALK: begin
          if (walk_next < count) begin
            walk_idx <= walk_next[pstq_pkg::AddrW-1:0];
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            range_sum <= res_sum;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the walk never writes an entry at or past the count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ({1'b0, walk_idx} < count))
    else $error("prefix walk beyond element count");

  // prefix table is written only by a load transfer or the update walk
  assert property (@(posedge clk) disable iff (rst)
    pfx_we |-> ((state == S_IDLE && in_xfer && mode == pstq_pkg::MODE_LOAD) ||
                state == S_WALK))
    else $error("unexpected prefix write");

  // an invalid query goes straight to a flagged result
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode == pstq_pkg::MODE_QUERY && query_bad) |=>
      (state == S_DONE && res_status == pstq_pkg::StatusBad && res_sum == '0))
    else $error("invalid query not flagged");

  // a result never overwrites one still waiting to be taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && state == S_DONE) |=> (state == S_DONE))
    else $error("result register overrun");
`endif

endmodule
